[hw/rtl/mpfd_pkg.sv]
// Shared types, constants and codes for the monochrome page framebuffer draw unit.
package mpfd_pkg;

	localparam int SCREEN_COLUMNS = 128;
	localparam int SCREEN_ROWS    = 64;

	localparam int OFFSET_W = 4;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 4'd4;

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_SPAN  = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] x_pos;
		logic [7:0] y_pos;
		logic [7:0] y_end;
		logic       color;
	} draw_t;

	typedef struct packed {
		logic       write_valid;
		logic [2:0] page;
		logic [7:0] column;
		logic [7:0] data;
		logic       pixel_value;
		logic       ok;
		logic       last;
	} result_t;

	typedef logic [OFFSET_W-1:0] offset_t;

	// Controller to datapath
	typedef struct packed {
		logic clear_step;
		logic accept;
		logic fire;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_done;
		logic out_free;
		logic last;
	} ctrl_sts_t;

endpackage

[hw/rtl/mpfd_stream_if.sv]
// Valid/ready channel carrying one payload per transfer.
interface mpfd_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/mono_page_framebuffer_draw_unit.sv]
// Top level of the monochrome page framebuffer draw unit.
//
// Channels: draw (sink) takes one draw item per transfer: action, x_pos,
// y_pos, y_end, color. result (source) gives one result per transfer; an
// item gives one result, a vertical span one per page touched (up to 8),
// with last set on the final one. cfg (sink) writes column_offset and is
// always ready; the user must write it only while the unit is idle, which
// the block itself does not enforce. Timing: a transfer loads the item
// registers and the read of its first page; each result is registered in
// the output register once it is free, and a new item is taken only after
// the last result of the previous one. Each page is one read-modify-write
// on the single frame store, whose read of the next page overlaps the write
// of the current one. Reset: column_offset returns to 4 and a clearing pass
// writes zero to all 2**(page bits + column bits) bytes of the frame store
// (1024 at the default size), one byte a cycle; draw is not ready during it.
// Stall: one finished result waits in the output register; while it is not
// taken the next page or item holds in place and nothing is lost.
module mono_page_framebuffer_draw_unit #(
	parameter int SCREEN_COLUMNS = mpfd_pkg::SCREEN_COLUMNS,
	parameter int SCREEN_ROWS    = mpfd_pkg::SCREEN_ROWS
) (
	input  logic          clk,
	input  logic          arst_n,
	mpfd_stream_if.sink   draw,
	mpfd_stream_if.source result,
	mpfd_stream_if.sink   cfg
);

	mpfd_pkg::ctrl_cmd_t cmd;
	mpfd_pkg::ctrl_sts_t sts;
	mpfd_pkg::result_t   res;
	logic                res_valid;
	logic                draw_ready;

	mpfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (draw.valid),
		.in_ready (draw_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mpfd_datapath #(
		.COLS (SCREEN_COLUMNS),
		.ROWS (SCREEN_ROWS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.item      (draw.payload),
		.cfg_write (cfg.valid),
		.cfg_value (cfg.payload),
		.res_valid (res_valid),
		.res_ready (result.ready),
		.res       (res)
	);

	assign draw.ready     = draw_ready;
	assign cfg.ready      = 1'b1;
	assign result.valid   = res_valid;
	assign result.payload = res;

endmodule

[hw/rtl/mpfd_ctrl.sv]
// Sequencer: post-reset clear pass, item accept and per-page execute steps.
module mpfd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mpfd_pkg::ctrl_sts_t sts,
	output mpfd_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;

	always_comb begin
		in_ready       = (state_q == ST_IDLE);
		cmd.clear_step = (state_q == ST_CLEAR);
		cmd.accept     = (state_q == ST_IDLE) && in_valid;
		cmd.fire       = (state_q == ST_EXEC) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clear_done) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					// stay for the next page of a span
					if (sts.out_free && sts.last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

endmodule

[hw/rtl/mpfd_datapath.sv]
// Frame store, item registers, byte update logic and result register.
module mpfd_datapath #(
	parameter int COLS = mpfd_pkg::SCREEN_COLUMNS,
	parameter int ROWS = mpfd_pkg::SCREEN_ROWS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mpfd_pkg::ctrl_cmd_t cmd,
	output mpfd_pkg::ctrl_sts_t sts,
	input  mpfd_pkg::draw_t     item,
	input  logic                cfg_write,
	input  mpfd_pkg::offset_t   cfg_value,
	output logic                res_valid,
	input  logic                res_ready,
	output mpfd_pkg::result_t   res
);

	localparam int PAGES = (ROWS + 7) / 8;
	localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int CW    = $clog2(COLS);
	localparam int AW    = PW + CW;
	localparam int DEPTH = 2 ** AW;

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	mpfd_pkg::offset_t offset_q;
	logic [AW-1:0]     clr_cnt_q;

	logic [1:0] act_q;
	logic [7:0] x_q;
	logic [7:0] cur_q;
	logic [7:0] hi_q;
	logic       color_q;
	logic       bad_q;

	logic              out_valid_q;
	mpfd_pkg::result_t out_q;

	// accept side
	logic [7:0] lo_d, hi_d, start_d;
	logic       bad_d;

	always_comb begin
		lo_d    = (item.y_pos > item.y_end) ? item.y_end : item.y_pos;
		hi_d    = (item.y_pos > item.y_end) ? item.y_pos : item.y_end;
		start_d = (item.action == mpfd_pkg::ACT_SPAN) ? lo_d : item.y_pos;
		case (item.action) inside
			mpfd_pkg::ACT_WRITE, mpfd_pkg::ACT_READ:
				bad_d = (item.x_pos >= 8'(COLS)) || (item.y_pos >= 8'(ROWS));
			mpfd_pkg::ACT_SPAN:
				bad_d = (item.x_pos >= 8'(COLS)) || (hi_d >= 8'(ROWS));
			default: bad_d = 1'b1;
		endcase
	end

	// execute side
	logic [7:0] pt_mask, top_mask, bot_mask, mask, new_byte, next_cur;
	logic       span_last, is_write, last;
	mpfd_pkg::result_t res_d;

	always_comb begin
		pt_mask   = 8'h01 << cur_q[2:0];
		top_mask  = 8'hFF << cur_q[2:0];
		bot_mask  = 8'hFF >> (3'd7 - hi_q[2:0]);
		span_last = (cur_q[7:3] == hi_q[7:3]);
		case (act_q)
			mpfd_pkg::ACT_SPAN: mask = span_last ? (top_mask & bot_mask) : top_mask;
			default:            mask = pt_mask;
		endcase
		new_byte = color_q ? (rd_data_q | mask) : (rd_data_q & ~mask);
		next_cur = (cur_q + 8'd8) & 8'h38;
		is_write = !bad_q && ((act_q == mpfd_pkg::ACT_WRITE) || (act_q == mpfd_pkg::ACT_SPAN));
		last     = bad_q || (act_q != mpfd_pkg::ACT_SPAN) || span_last;

		res_d.write_valid = is_write;
		res_d.page        = is_write ? cur_q[5:3] : 3'd0;
		res_d.column      = is_write ? (x_q + {4'd0, offset_q}) : 8'd0;
		res_d.data        = is_write ? new_byte : 8'd0;
		res_d.pixel_value = !bad_q && (act_q == mpfd_pkg::ACT_READ) && |(rd_data_q & pt_mask);
		res_d.ok          = !bad_q;
		res_d.last        = last;
	end

	// store ports
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [7:0]    wr_data;

	always_comb begin
		rd_en   = cmd.accept || (cmd.fire && !last);
		rd_addr = cmd.accept ? {start_d[PW+2:3], item.x_pos[CW-1:0]}
		                     : {next_cur[PW+2:3], x_q[CW-1:0]};
		wr_en   = cmd.clear_step || (cmd.fire && is_write);
		wr_addr = cmd.clear_step ? clr_cnt_q : {cur_q[PW+2:3], x_q[CW-1:0]};
		wr_data = cmd.clear_step ? 8'd0 : new_byte;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	assign sts.clear_done = cmd.clear_step && (clr_cnt_q == '1);
	assign sts.out_free   = !out_valid_q || res_ready;
	assign sts.last       = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= mpfd_pkg::OFFSET_RESET;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) offset_q <= cfg_value;
			if (cmd.clear_step) clr_cnt_q <= clr_cnt_q + AW'(1);
			if (cmd.fire) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q   <= item.action;
			x_q     <= item.x_pos;
			cur_q   <= start_d;
			hi_q    <= hi_d;
			color_q <= item.color;
			bad_q   <= bad_d;
		end else if (cmd.fire && !last) begin
			cur_q <= next_cur;
		end
		if (cmd.fire) out_q <= res_d;
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	a_no_clear_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clear_step && (cmd.fire || cmd.accept)))
		else $error("clear pass overlaps item work");

	a_fire_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fire |-> (!out_valid_q || res_ready))
		else $error("result register overwritten");

	a_no_port_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("read and write of the same byte in one cycle");

	a_reject_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.ok) |-> (!out_q.write_valid && out_q.last))
		else $error("rejected item produced a write or a continuation");

	a_span_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fire && !last) |=> (!cmd.accept && (cur_q == $past(next_cur))))
		else $error("span did not advance to the next page");

endmodule
